// ===== design/fpa_pkg.sv =====
// Shared definitions for the Q24.8 fixed-point ALU: default widths, operation codes and the flag type.
// No dependencies.
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int OP_BITS   = 4;

  localparam logic [OP_BITS-1:0] OP_ADD      = 4'd0;
  localparam logic [OP_BITS-1:0] OP_SUB      = 4'd1;
  localparam logic [OP_BITS-1:0] OP_MUL      = 4'd2;
  localparam logic [OP_BITS-1:0] OP_DIV      = 4'd3;
  localparam logic [OP_BITS-1:0] OP_EQ       = 4'd4;
  localparam logic [OP_BITS-1:0] OP_LE       = 4'd5;
  localparam logic [OP_BITS-1:0] OP_LT       = 4'd6;
  localparam logic [OP_BITS-1:0] OP_GT       = 4'd7;
  localparam logic [OP_BITS-1:0] OP_GE       = 4'd8;
  localparam logic [OP_BITS-1:0] OP_MIN      = 4'd9;
  localparam logic [OP_BITS-1:0] OP_MAX      = 4'd10;
  localparam logic [OP_BITS-1:0] OP_INC      = 4'd11;
  localparam logic [OP_BITS-1:0] OP_DEC      = 4'd12;
  localparam logic [OP_BITS-1:0] OP_TO_INT   = 4'd13;
  localparam logic [OP_BITS-1:0] OP_FROM_INT = 4'd14;

  // flags that go with a result out of the result select
  typedef struct packed {
    logic cmp;
    logic dbz;
    logic sat;
  } fpa_flags_t;

endpackage

// ===== design/fixed_point_q24_8_alu.sv =====
// Top level of the Q24.8 fixed-point ALU: front stage, multiplier, divider, result select.
// Uses fpa_pkg, fpa_front, fpa_mul, fpa_div.
//
//   channel   signals                                        transfer when
//   request   start, busy, req_type, operand_a, operand_b    start && !busy
//   result    done, result, compare_true, divide_by_zero,    done (one cycle)
//             saturated
//
// One request can enter every cycle; busy is never raised.
// Every operation goes through a path as deep as the divider, one quotient bit per
// stage; shorter paths are delayed to match, so results leave in request order.
// Reset clears the valid bits only.
// The result side cannot stall, so nothing in the pipeline ever holds.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu #(
  parameter int WORD_BITS = fpa_pkg::WORD_BITS,
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [fpa_pkg::OP_BITS-1:0]  req_type,
  input  logic signed [WORD_BITS-1:0]  operand_a,
  input  logic signed [WORD_BITS-1:0]  operand_b,
  output logic                         done,
  output logic signed [WORD_BITS-1:0]  result,
  output logic                         compare_true,
  output logic                         divide_by_zero,
  output logic                         saturated
);

  localparam int N     = WORD_BITS + FRAC_BITS;
  localparam int DLAT  = N + 2;
  localparam int MDLY  = DLAT - 3;

  logic                        v_front;
  logic [fpa_pkg::OP_BITS-1:0] f_op;
  logic [WORD_BITS-1:0]        f_ma, f_mb, f_res;
  logic                        f_neg, f_bz, f_cmp;

  logic [WORD_BITS-1:0]        mul_res, div_res;
  logic                        mul_sat, div_sat;

  // sideband delay line, matched to the divider
  logic                        sd_v   [0:DLAT-1];
  logic [fpa_pkg::OP_BITS-1:0] sd_op  [0:DLAT-1];
  logic [WORD_BITS-1:0]        sd_res [0:DLAT-1];
  logic                        sd_bz  [0:DLAT-1];
  logic                        sd_cmp [0:DLAT-1];

  logic [WORD_BITS-1:0]        md_res [0:MDLY-1];
  logic                        md_sat [0:MDLY-1];

  logic [WORD_BITS-1:0]        out_res;
  fpa_pkg::fpa_flags_t         out_flags;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_front <= 1'b0;
    end else begin
      v_front <= start & ~busy;
    end
  end

  fpa_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .op         (req_type),
    .a          (operand_a),
    .b          (operand_b),
    .op_q       (f_op),
    .mag_a      (f_ma),
    .mag_b      (f_mb),
    .neg        (f_neg),
    .b_zero     (f_bz),
    .simple_res (f_res),
    .cmp        (f_cmp)
  );

  fpa_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .mag_a (f_ma),
    .mag_b (f_mb),
    .neg   (f_neg),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  fpa_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .mag_a (f_ma),
    .mag_b (f_mb),
    .neg   (f_neg),
    .res   (div_res),
    .sat   (div_sat)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLAT; i++) sd_v[i] <= 1'b0;
    end else begin
      sd_v[0] <= v_front;
      for (int i = 1; i < DLAT; i++) sd_v[i] <= sd_v[i-1];
    end
  end

  // sideband payload and multiplier alignment
  always_ff @(posedge clk) begin
    sd_op[0]  <= f_op;
    sd_res[0] <= f_res;
    sd_bz[0]  <= f_bz;
    sd_cmp[0] <= f_cmp;
    for (int i = 1; i < DLAT; i++) begin
      sd_op[i]  <= sd_op[i-1];
      sd_res[i] <= sd_res[i-1];
      sd_bz[i]  <= sd_bz[i-1];
      sd_cmp[i] <= sd_cmp[i-1];
    end
    md_res[0] <= mul_res;
    md_sat[0] <= mul_sat;
    for (int i = 1; i < MDLY; i++) begin
      md_res[i] <= md_res[i-1];
      md_sat[i] <= md_sat[i-1];
    end
  end

  // result select
  always_comb begin
    out_res   = sd_res[DLAT-1];
    out_flags = '{cmp: sd_cmp[DLAT-1], dbz: 1'b0, sat: 1'b0};
    case (sd_op[DLAT-1])
      fpa_pkg::OP_MUL: begin
        out_res   = md_res[MDLY-1];
        out_flags = '{cmp: 1'b0, dbz: 1'b0, sat: md_sat[MDLY-1]};
      end
      fpa_pkg::OP_DIV: begin
        if (sd_bz[DLAT-1]) begin
          out_res   = '0;
          out_flags = '{cmp: 1'b0, dbz: 1'b1, sat: 1'b0};
        end else begin
          out_res   = div_res;
          out_flags = '{cmp: 1'b0, dbz: 1'b0, sat: div_sat};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sd_v[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    result         <= out_res;
    compare_true   <= out_flags.cmp;
    divide_by_zero <= out_flags.dbz;
    saturated      <= out_flags.sat;
  end

endmodule

// ===== design/fpa_front.sv =====
// Front stage: operand magnitudes, result sign, zero test of b, and all operations but multiply and divide.
// Uses fpa_pkg.
`timescale 1ns / 1ps

module fpa_front #(
  parameter int WORD_BITS = fpa_pkg::WORD_BITS,
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic [fpa_pkg::OP_BITS-1:0]   op,
  input  logic signed [WORD_BITS-1:0]   a,
  input  logic signed [WORD_BITS-1:0]   b,
  output logic [fpa_pkg::OP_BITS-1:0]   op_q,
  output logic [WORD_BITS-1:0]          mag_a,
  output logic [WORD_BITS-1:0]          mag_b,
  output logic                          neg,
  output logic                          b_zero,
  output logic [WORD_BITS-1:0]          simple_res,
  output logic                          cmp
);

  logic [WORD_BITS-1:0] au, bu, ma, mb, t, res_c;
  logic                 lt, eq, cmp_c;

  // magnitudes and signed order
  always_comb begin
    au = a;
    bu = b;
    ma = a[WORD_BITS-1] ? (~au + WORD_BITS'(1)) : au;
    mb = b[WORD_BITS-1] ? (~bu + WORD_BITS'(1)) : bu;
    lt = a < b;
    eq = au == bu;
    t  = ma >> FRAC_BITS;
  end

  // operations other than multiply and divide
  always_comb begin
    res_c = '0;
    cmp_c = 1'b0;
    case (op)
      fpa_pkg::OP_ADD:      res_c = au + bu;
      fpa_pkg::OP_SUB:      res_c = au - bu;
      fpa_pkg::OP_EQ:       cmp_c = eq;
      fpa_pkg::OP_LE:       cmp_c = lt | eq;
      fpa_pkg::OP_LT:       cmp_c = lt;
      fpa_pkg::OP_GT:       cmp_c = ~(lt | eq);
      fpa_pkg::OP_GE:       cmp_c = ~lt;
      fpa_pkg::OP_MIN:      res_c = lt ? au : bu;
      fpa_pkg::OP_MAX:      res_c = (~(lt | eq)) ? au : bu;
      fpa_pkg::OP_INC:      res_c = au + WORD_BITS'(1);
      fpa_pkg::OP_DEC:      res_c = au - WORD_BITS'(1);
      fpa_pkg::OP_TO_INT:   res_c = a[WORD_BITS-1] ? (~t + WORD_BITS'(1)) : t;
      fpa_pkg::OP_FROM_INT: res_c = au << FRAC_BITS;
      default:              res_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    op_q       <= op;
    mag_a      <= ma;
    mag_b      <= mb;
    neg        <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
    b_zero     <= bu == '0;
    simple_res <= res_c;
    cmp        <= cmp_c;
  end

endmodule

// ===== design/fpa_mul.sv =====
// Pipelined fixed-point multiplier: half-word partial products, sum with rounding, clamp.
// Partial products, sum and clamp are each registered. Uses fpa_pkg for parameter defaults.
`timescale 1ns / 1ps

module fpa_mul #(
  parameter int WORD_BITS = fpa_pkg::WORD_BITS,
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic [WORD_BITS-1:0] mag_a,
  input  logic [WORD_BITS-1:0] mag_b,
  input  logic                 neg,
  output logic [WORD_BITS-1:0] res,
  output logic                 sat
);

  localparam int H = (WORD_BITS + 1) / 2;
  localparam int L = WORD_BITS - H;
  localparam int P = 2 * WORD_BITS;

  logic [2*H-1:0] ll;
  logic [H+L-1:0] lh, hl;
  logic [2*L-1:0] hh;
  logic           neg_1, neg_2;
  logic [P-1:0]   sum, prod;
  logic [P-1:0]   limit;

  // partial products
  always_ff @(posedge clk) begin
    ll    <= mag_a[H-1:0] * mag_b[H-1:0];
    lh    <= mag_a[H-1:0] * mag_b[WORD_BITS-1:H];
    hl    <= mag_a[WORD_BITS-1:H] * mag_b[H-1:0];
    hh    <= mag_a[WORD_BITS-1:H] * mag_b[WORD_BITS-1:H];
    neg_1 <= neg;
  end

  // sum, add half an lsb, drop the fraction
  always_comb begin
    sum = P'(ll) + (P'(lh) << H) + (P'(hl) << H) + (P'(hh) << (2 * H))
        + (P'(1) << (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    prod  <= sum >> FRAC_BITS;
    neg_2 <= neg_1;
  end

  // clamp to the word range
  always_comb limit = (P'(1) << (WORD_BITS - 1)) - P'(!neg_2);

  always_ff @(posedge clk) begin
    if (prod > limit) begin
      sat <= 1'b1;
      res <= limit[WORD_BITS-1:0];
    end else begin
      sat <= 1'b0;
      res <= neg_2 ? (~prod[WORD_BITS-1:0] + WORD_BITS'(1)) : prod[WORD_BITS-1:0];
    end
  end

endmodule

// ===== design/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, then rounding and clamp.
// Each step, the rounding and the clamp are registered. Uses fpa_pkg for parameter defaults.
`timescale 1ns / 1ps

module fpa_div #(
  parameter int WORD_BITS = fpa_pkg::WORD_BITS,
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic [WORD_BITS-1:0] mag_a,
  input  logic [WORD_BITS-1:0] mag_b,
  input  logic                 neg,
  output logic [WORD_BITS-1:0] res,
  output logic                 sat
);

  localparam int N = WORD_BITS + FRAC_BITS;

  logic [WORD_BITS-1:0] rem_s [0:N-1];
  logic [N-1:0]         num_s [0:N-1];
  logic [N-1:0]         quo_s [0:N-1];
  logic [WORD_BITS-1:0] den_s [0:N-1];
  logic                 neg_s [0:N-1];

  logic [N:0]           q_rnd;
  logic                 neg_r;
  logic [N:0]           limit;

  // one shift-subtract step per stage
  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_step
      logic [WORD_BITS-1:0] rem_in, den_in;
      logic [N-1:0]         num_in, quo_in;
      logic                 neg_in;
      logic [WORD_BITS:0]   trial;
      logic                 take;
      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign num_in = {mag_a, FRAC_BITS'(0)};
        assign quo_in = '0;
        assign den_in = mag_b;
        assign neg_in = neg;
      end else begin : g_next
        assign rem_in = rem_s[k-1];
        assign num_in = num_s[k-1];
        assign quo_in = quo_s[k-1];
        assign den_in = den_s[k-1];
        assign neg_in = neg_s[k-1];
      end
      assign trial = {rem_in, num_in[N-1]};
      assign take  = trial >= {1'b0, den_in};
      always_ff @(posedge clk) begin
        rem_s[k] <= take ? WORD_BITS'(trial - {1'b0, den_in}) : trial[WORD_BITS-1:0];
        num_s[k] <= num_in << 1;
        quo_s[k] <= {quo_in[N-2:0], take};
        den_s[k] <= den_in;
        neg_s[k] <= neg_in;
      end
    end
  endgenerate

  // round half away from zero on the magnitude
  always_ff @(posedge clk) begin
    q_rnd <= {1'b0, quo_s[N-1]}
           + (N+1)'(rem_s[N-1] >= (den_s[N-1] - rem_s[N-1]));
    neg_r <= neg_s[N-1];
  end

  // clamp to the word range
  always_comb limit = ((N+1)'(1) << (WORD_BITS - 1)) - (N+1)'(!neg_r);

  always_ff @(posedge clk) begin
    if (q_rnd > limit) begin
      sat <= 1'b1;
      res <= limit[WORD_BITS-1:0];
    end else begin
      sat <= 1'b0;
      res <= neg_r ? (~q_rnd[WORD_BITS-1:0] + WORD_BITS'(1)) : q_rnd[WORD_BITS-1:0];
    end
  end

endmodule

// ===== design/fpa_checker.sv =====
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_q24_8_alu.
`timescale 1ns / 1ps

module fpa_checker #(
  parameter int WORD_BITS = fpa_pkg::WORD_BITS,
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [WORD_BITS-1:0] result,
  input logic                 compare_true,
  input logic                 divide_by_zero,
  input logic                 saturated
);

  localparam int LAT = WORD_BITS + FRAC_BITS + 4;

  // the receiver cannot stall, so requests are never held off
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every request transfer yields one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result missing after request");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without request");

  // divide by zero returns zero with no other flag
  a_dbz: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (result == '0 && !saturated && !compare_true))
    else $error("divide by zero result wrong");

  // compares return zero with no other flag
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    (done && compare_true) |-> (result == '0 && !saturated && !divide_by_zero))
    else $error("compare result wrong");

endmodule

bind fixed_point_q24_8_alu fpa_checker #(
  .WORD_BITS(WORD_BITS),
  .FRAC_BITS(FRAC_BITS)
) u_fpa_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .result         (result),
  .compare_true   (compare_true),
  .divide_by_zero (divide_by_zero),
  .saturated      (saturated)
);
